// ===== rtl/cft_pkg.sv =====
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types, codes and defaults for the category frequency trimmer.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam int CODE_W    = 10;
  localparam int KEPT_W    = 11;
  localparam int FREQ_W    = 32;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam int NUM_CODES_DEF  = 1024;
  localparam int COUNT_BITS_DEF = 32;

  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TRIM  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CATS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIMMED_CODE = 2'd2;

  localparam logic [FREQ_W-1:0] MIN_FREQ_RST     = '0;
  localparam logic [KEPT_W-1:0] MAX_CATS_RST     = 11'd1024;
  localparam logic [CODE_W-1:0] TRIMMED_CODE_RST = '0;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CODE_W-1:0] value;
    logic              is_null;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] out_code;
    logic [KEPT_W-1:0] kept_total;
  } out_item_t;

  typedef struct packed {
    logic ld_item;
    logic sweep_rst;
    logic sweep_clr;
    logic mark_clr;
    logic rd_item;
    logic wr_inc;
    logic scan_start;
    logic scan_rd;
    logic mark_best;
    logic kept_rst;
    logic ld_trim;
    logic ld_build;
  } ctl_cmd_t;

  typedef struct packed {
    logic addr_last;
    logic item_ok;
    logic best_found;
    logic kept_full;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== rtl/cft_datapath.sv =====
// ----------------------------------------------------------------------------
// cft_datapath
// Count and mark memories, scan best-tracking, config and output registers.
// ----------------------------------------------------------------------------
module cft_datapath #(
  parameter int NUM_CODES  = cft_pkg::NUM_CODES_DEF,
  parameter int COUNT_BITS = cft_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cft_pkg::in_item_t                in_item,
  input  logic                             cfg_valid,
  input  logic [cft_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cft_pkg::FREQ_W-1:0]       cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output cft_pkg::out_item_t               out_item,
  input  cft_pkg::ctl_cmd_t                cmd,
  output cft_pkg::ctl_sts_t                sts
);

  localparam int AW    = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;
  localparam int CMP_W = (COUNT_BITS > cft_pkg::FREQ_W) ? COUNT_BITS : cft_pkg::FREQ_W;
  localparam logic [AW-1:0] ADDR_LAST = AW'(NUM_CODES - 1);

  logic [COUNT_BITS-1:0] cnt_mem [NUM_CODES];
  logic                  mark_mem [NUM_CODES];

  cft_pkg::in_item_t             item_r;
  logic [AW-1:0]                 addr_r;
  logic [COUNT_BITS-1:0]         cnt_q_r;
  logic                          mark_q_r;
  logic                          scan_vld_r;
  logic [AW-1:0]                 scan_idx_r;
  logic                          best_found_r;
  logic [COUNT_BITS-1:0]         best_cnt_r;
  logic [AW-1:0]                 best_addr_r;
  logic [cft_pkg::KEPT_W-1:0]    kept_r;
  logic [cft_pkg::FREQ_W-1:0]    min_freq_r;
  logic [cft_pkg::KEPT_W-1:0]    max_cats_r;
  logic [cft_pkg::CODE_W-1:0]    trimmed_code_r;
  logic                          out_valid_r;
  cft_pkg::out_item_t            out_item_r;

  logic [AW-1:0]         item_addr;
  logic [AW-1:0]         rd_addr;
  logic                  rd_en;
  logic                  cand;
  logic [COUNT_BITS-1:0] cnt_inc;

  assign item_addr = AW'(item_r.value);
  assign rd_addr   = cmd.rd_item ? item_addr : addr_r;
  assign rd_en     = cmd.rd_item | cmd.scan_rd;
  assign cnt_inc   = (&cnt_q_r) ? cnt_q_r : cnt_q_r + COUNT_BITS'(1);

  assign cand = scan_vld_r && (cnt_q_r != '0) && !mark_q_r &&
                (CMP_W'(cnt_q_r) >= CMP_W'(min_freq_r)) &&
                (!best_found_r || (cnt_q_r > best_cnt_r));

  always_ff @(posedge clk) begin
    if (cmd.sweep_clr) begin
      cnt_mem[addr_r] <= '0;
    end else if (cmd.wr_inc) begin
      cnt_mem[item_addr] <= cnt_inc;
    end
    if (cmd.sweep_clr || cmd.mark_clr) begin
      mark_mem[addr_r] <= 1'b0;
    end else if (cmd.mark_best) begin
      mark_mem[best_addr_r] <= 1'b1;
    end
    if (rd_en) begin
      cnt_q_r  <= cnt_mem[rd_addr];
      mark_q_r <= mark_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      item_r <= in_item;
    end
    scan_idx_r <= addr_r;
    if (cand) begin
      best_cnt_r  <= cnt_q_r;
      best_addr_r <= scan_idx_r;
    end
    if (cmd.ld_trim) begin
      out_item_r.out_code   <= (sts.item_ok && mark_q_r) ? item_r.value : trimmed_code_r;
      out_item_r.kept_total <= '0;
    end else if (cmd.ld_build) begin
      out_item_r.out_code   <= '0;
      out_item_r.kept_total <= kept_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r         <= '0;
      scan_vld_r     <= 1'b0;
      best_found_r   <= 1'b0;
      kept_r         <= '0;
      min_freq_r     <= cft_pkg::MIN_FREQ_RST;
      max_cats_r     <= cft_pkg::MAX_CATS_RST;
      trimmed_code_r <= cft_pkg::TRIMMED_CODE_RST;
      out_valid_r    <= 1'b0;
    end else begin
      if (cmd.sweep_rst || cmd.scan_start) begin
        addr_r <= '0;
      end else if (cmd.sweep_clr || cmd.mark_clr || cmd.scan_rd) begin
        addr_r <= (addr_r == ADDR_LAST) ? '0 : addr_r + AW'(1);
      end
      scan_vld_r <= cmd.scan_rd;
      if (cmd.scan_start) begin
        best_found_r <= 1'b0;
      end else if (cand) begin
        best_found_r <= 1'b1;
      end
      if (cmd.kept_rst) begin
        kept_r <= '0;
      end else if (cmd.mark_best) begin
        kept_r <= kept_r + cft_pkg::KEPT_W'(1);
      end
      if (cfg_valid) begin
        case (cfg_index)
          cft_pkg::CFG_MIN_FREQ:     min_freq_r     <= cfg_data;
          cft_pkg::CFG_MAX_CATS:     max_cats_r     <= cfg_data[cft_pkg::KEPT_W-1:0];
          cft_pkg::CFG_TRIMMED_CODE: trimmed_code_r <= cfg_data[cft_pkg::CODE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.ld_trim || cmd.ld_build) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.addr_last  = (addr_r == ADDR_LAST);
  assign sts.item_ok    = !item_r.is_null && (32'(item_r.value) < 32'(NUM_CODES));
  assign sts.best_found = best_found_r;
  assign sts.kept_full  = (kept_r >= max_cats_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/cft_ctrl.sv =====
// ----------------------------------------------------------------------------
// cft_ctrl
// Sequencer for clear sweeps, count updates, trims and the kept-set build.
// ----------------------------------------------------------------------------
module cft_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [cft_pkg::CMD_W-1:0]     in_cmd,
  output logic                          in_ready,
  output cft_pkg::ctl_cmd_t             cmd,
  input  cft_pkg::ctl_sts_t             sts
);

  localparam logic [3:0] S_CLR       = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_CNT_RD    = 4'd2;
  localparam logic [3:0] S_CNT_WR    = 4'd3;
  localparam logic [3:0] S_TRIM_RD   = 4'd4;
  localparam logic [3:0] S_TRIM_OUT  = 4'd5;
  localparam logic [3:0] S_MCLR      = 4'd6;
  localparam logic [3:0] S_SCAN      = 4'd7;
  localparam logic [3:0] S_SCAN_END  = 4'd8;
  localparam logic [3:0] S_MARK      = 4'd9;
  localparam logic [3:0] S_BUILD_OUT = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.sweep_clr = 1'b1;
        if (sts.addr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_item   = 1'b1;
          cmd.sweep_rst = 1'b1;
          case (in_cmd)
            cft_pkg::CMD_COUNT: state_nxt = S_CNT_RD;
            cft_pkg::CMD_BUILD: begin
              cmd.kept_rst = 1'b1;
              state_nxt    = S_MCLR;
            end
            cft_pkg::CMD_TRIM:  state_nxt = S_TRIM_RD;
            default: begin
              cmd.kept_rst = 1'b1;
              state_nxt    = S_CLR;
            end
          endcase
        end
      end
      S_CNT_RD: begin
        if (sts.item_ok) begin
          cmd.rd_item = 1'b1;
          state_nxt   = S_CNT_WR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CNT_WR: begin
        cmd.wr_inc = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_TRIM_RD: begin
        cmd.rd_item = 1'b1;
        state_nxt   = S_TRIM_OUT;
      end
      S_TRIM_OUT: begin
        if (sts.out_free) begin
          cmd.ld_trim = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_MCLR: begin
        cmd.mark_clr = 1'b1;
        if (sts.addr_last) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.addr_last) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: state_nxt = S_MARK;
      S_MARK: begin
        if (sts.best_found && !sts.kept_full) begin
          cmd.mark_best  = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          state_nxt = S_BUILD_OUT;
        end
      end
      S_BUILD_OUT: begin
        if (sts.out_free) begin
          cmd.ld_build = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_ld_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ld_trim || cmd.ld_build) |-> sts.out_free)
    else $error("result loaded while output beat still held");

  a_mark_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_best |-> (sts.best_found && !sts.kept_full))
    else $error("mark written without a valid best candidate");

  a_busy_after_rst: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !in_ready)
    else $error("input taken before clearing sweep");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_END) |=> (state_r == S_MARK))
    else $error("scan did not settle into mark decision");

endmodule

// ===== rtl/category_frequency_trimmer_core.sv =====
// ----------------------------------------------------------------------------
// category_frequency_trimmer_core
// Per-code occurrence counting with top-k kept-set build and value trimming.
// ----------------------------------------------------------------------------
// Count: read, increment-write, back to idle; a null or out-of-range code skips both.
// Trim: the mark is read, then the result beat is registered once the output is free.
// Build: a mark-clearing pass, then one selection scan of the count memory
//   per kept code plus a final one, one memory read per cycle during a scan.
// Clear item: one count and mark entry zeroed per cycle over the whole memory.
// Reset: synchronous; a clearing pass over every memory entry follows with in_ready low.
module category_frequency_trimmer_core #(
  parameter int NUM_CODES  = cft_pkg::NUM_CODES_DEF,
  parameter int COUNT_BITS = cft_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cft_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cft_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cft_pkg::FREQ_W-1:0]    cfg_data
);

  cft_pkg::ctl_cmd_t cmd;
  cft_pkg::ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  cft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_item.cmd),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  cft_datapath #(
    .NUM_CODES  (NUM_CODES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
